// ===== design/blz_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the backward LZ77 decompressor.
// No dependencies; every other file imports this package.
package blz_pkg;

  localparam int WIN_DEPTH = 8192;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam logic [WIN_AW:0]   WIN_DEPTH_X = (WIN_AW+1)'(WIN_DEPTH);
  localparam logic [WIN_AW-1:0] WIN_LAST    = WIN_AW'(WIN_DEPTH - 1);

  localparam int CFG_W = 24;
  localparam logic [CFG_W-1:0] CNT_MAX = 24'hFFFFFF;

  localparam logic [4:0] MIN_MATCH = 5'd3;
  localparam logic [7:0] FLAG_MSB  = 8'h80;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'b001,
    PH_TOKEN = 3'b010,
    PH_PAIR2 = 3'b100
  } phase_t;

  // One token for the back end: a literal or a copy pair.
  typedef struct packed {
    logic       is_copy;
    logic [7:0] lo;      // literal byte, or low distance bits
    logic [7:0] hi;      // pair high byte: length nibble, distance nibble
    logic       done;    // token ends the stream
  } blz_cmd_t;

endpackage

// ===== design/blz_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: compressed input, byte output, config write.
// Depends on blz_pkg.
interface blz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, in_byte, input ready);
  modport sink   (input valid, in_byte, output ready);
endinterface

interface blz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;
  modport source (output valid, out_byte, run_last, stream_done, input ready);
  modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

interface blz_cfg_if import blz_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] compressed_length;
  modport source (output valid, compressed_length, input ready);
  modport sink   (input valid, compressed_length, output ready);
endinterface

// ===== design/blz_front.sv =====
`timescale 1ns / 1ps
// Front end: parses flag bytes and tokens, counts consumed bytes, holds the
// length register and pushes tokens to the queue. Depends on blz_pkg, blz_if.
module blz_front import blz_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  blz_in_if.sink   in_ch,
  blz_cfg_if.sink  cfg_ch,
  input  logic     q_full,
  output logic     push,
  output blz_cmd_t push_cmd
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [2:0]       tidx_r, tidx_nxt;
  logic [7:0]       pair_hi_r, pair_hi_nxt;
  logic [CFG_W-1:0] cnt_r, cnt_nxt;
  logic             fin_r, fin_nxt;
  logic [CFG_W-1:0] clen_r;
  logic             in_fire;
  logic             token_done;

  assign in_ch.ready  = fin_r || !q_full;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    tidx_nxt    = tidx_r;
    pair_hi_nxt = pair_hi_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    token_done  = 1'b0;
    push        = 1'b0;
    push_cmd    = '{is_copy: 1'b0, lo: in_ch.in_byte, hi: pair_hi_r, done: 1'b0};
    if (in_fire && !fin_r) begin
      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 1'b1;
      unique case (phase_r)
        PH_FLAG: begin
          flags_nxt = in_ch.in_byte;
          phase_nxt = PH_TOKEN;
        end
        PH_TOKEN: begin
          if ((flags_r & FLAG_MSB) == 8'h00) begin
            push       = 1'b1;
            token_done = 1'b1;
          end else begin
            pair_hi_nxt = in_ch.in_byte;
            phase_nxt   = PH_PAIR2;
          end
        end
        PH_PAIR2: begin
          push             = 1'b1;
          push_cmd.is_copy = 1'b1;
          token_done       = 1'b1;
        end
        default: phase_nxt = PH_FLAG;
      endcase
      if (token_done) begin
        flags_nxt = {flags_r[6:0], 1'b0};
        tidx_nxt  = tidx_r + 1'b1;
        phase_nxt = (tidx_nxt == 3'd0) ? PH_FLAG : PH_TOKEN;
        fin_nxt   = cnt_nxt >= clen_r;
      end
      push_cmd.done = fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FLAG;
      flags_r   <= '0;
      tidx_r    <= '0;
      pair_hi_r <= '0;
      cnt_r     <= '0;
      fin_r     <= 1'b0;
      clen_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      flags_r   <= flags_nxt;
      tidx_r    <= tidx_nxt;
      pair_hi_r <= pair_hi_nxt;
      cnt_r     <= cnt_nxt;
      fin_r     <= fin_nxt;
      if (cfg_ch.valid && cfg_ch.ready) clen_r <= cfg_ch.compressed_length;
    end
  end

endmodule

// ===== design/blz_cmd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry token queue between the parser and the copy engine.
// Depends on blz_pkg.
module blz_cmd_queue import blz_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  blz_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output blz_cmd_t head_cmd
);

  blz_cmd_t   slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/blz_back.sv =====
`timescale 1ns / 1ps
// Back end: expands tokens into bytes through the history window memory and
// drives the output register. Depends on blz_pkg, blz_if.
module blz_back import blz_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  blz_cmd_t head_cmd,
  output logic     pop,
  blz_out_if.source out_ch
);

  // active token
  logic              act_v_r;
  logic [4:0]        act_cnt_r;
  logic [WIN_AW-1:0] act_dist_r;
  logic              act_copy_r;
  logic [7:0]        act_lit_r;
  logic              act_done_r;
  // window issue pointer and fill flag
  logic [WIN_AW-1:0] ip_r;
  logic              wrapped_r;
  // read stage
  logic              rd_v_r;
  logic [WIN_AW-1:0] rd_dest_r;
  logic              rd_copy_r;
  logic              rd_hit_r;
  logic [7:0]        rd_lit_r;
  logic              rd_last_r;
  logic              rd_done_r;
  logic [7:0]        q_r;
  // output register
  logic              out_v_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_done_r;

  logic [7:0]        win_mem [WIN_DEPTH];

  logic              can_load, adv_rd, issue;
  logic [WIN_AW-1:0] src_addr;
  logic [WIN_AW:0]   src_wrap;
  logic [7:0]        byte_val;

  assign can_load = !out_v_r || out_ch.ready;
  assign adv_rd   = rd_v_r && can_load;
  assign issue    = act_v_r && (!rd_v_r || can_load);
  assign pop      = !act_v_r && head_valid;

  assign src_wrap = {1'b0, ip_r} + (WIN_DEPTH_X - {1'b0, act_dist_r});
  assign src_addr = (ip_r >= act_dist_r) ? (ip_r - act_dist_r) : src_wrap[WIN_AW-1:0];
  // a slot never written reads as zero
  assign byte_val = !rd_copy_r ? rd_lit_r : (rd_hit_r ? q_r : 8'h00);

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.run_last    = out_last_r;
  assign out_ch.stream_done = out_done_r;

  always_ff @(posedge clk) begin
    if (adv_rd) win_mem[rd_dest_r] <= byte_val;
    if (issue && act_copy_r) q_r <= win_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      act_copy_r <= head_cmd.is_copy;
      act_lit_r  <= head_cmd.lo;
      act_done_r <= head_cmd.done;
      act_dist_r <= WIN_AW'({head_cmd.hi[3:0], head_cmd.lo}) + WIN_AW'(MIN_MATCH);
    end
    if (issue) begin
      rd_dest_r <= ip_r;
      rd_copy_r <= act_copy_r;
      rd_hit_r  <= wrapped_r || (ip_r >= act_dist_r);
      rd_lit_r  <= act_lit_r;
      rd_last_r <= act_cnt_r == 5'd1;
      rd_done_r <= act_done_r;
    end
    if (adv_rd) begin
      out_byte_r <= byte_val;
      out_last_r <= rd_last_r;
      out_done_r <= rd_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r   <= 1'b0;
      act_cnt_r <= '0;
      ip_r      <= '0;
      wrapped_r <= 1'b0;
      rd_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (pop) begin
        act_v_r   <= 1'b1;
        act_cnt_r <= head_cmd.is_copy ? ({1'b0, head_cmd.hi[7:4]} + MIN_MATCH) : 5'd1;
      end else if (issue) begin
        act_cnt_r <= act_cnt_r - 1'b1;
        if (act_cnt_r == 5'd1) act_v_r <= 1'b0;
      end
      if (issue) begin
        if (ip_r == WIN_LAST) begin
          ip_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          ip_r <= ip_r + 1'b1;
        end
      end
      if (issue)       rd_v_r <= 1'b1;
      else if (adv_rd) rd_v_r <= 1'b0;
      if (adv_rd)            out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_act_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    act_v_r |-> act_cnt_r != 5'd0)
    else $error("active token with zero byte count");

  a_token_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && act_cnt_r == 5'd1) |=> !act_v_r)
    else $error("token still active after its last byte");

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_v_r && !can_load) |=> (rd_v_r && $stable(rd_dest_r)))
    else $error("read stage lost a byte while stalled");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !issue)
    else $error("token loaded while another issues");
`endif

endmodule

// ===== design/backward_lz77_decompressor.sv =====
`timescale 1ns / 1ps
// Top level of the backward LZ77 decompressor: parser, token queue, copy engine.
// Depends on blz_pkg, blz_if, blz_front, blz_cmd_queue, blz_back.
//
//   channel  dir  payload                               beat when
//   in_ch    in   in_byte[7:0]                          valid && ready
//   out_ch   out  out_byte[7:0], run_last, stream_done  valid && ready
//   cfg_ch   in   compressed_length[23:0]               valid && ready
//
// Each output byte uses the window memory (one read and one write per cycle
// unless out_ch stalls); a token is taken from the queue only after the last
// byte of the token before has issued. A literal passes the queue, active token,
// read stage and output register; a pair's second byte produces 3 to 18 bytes.
// No clearing pass after reset: unwritten window slots read as zero via a fill flag.
// in_ch stalls only while the two-entry token queue is full; out_ch stalls hold
// the copy engine in place.
module backward_lz77_decompressor import blz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  blz_in_if.sink    in_ch,
  blz_cfg_if.sink   cfg_ch,
  blz_out_if.source out_ch
);

  logic     push, q_full, pop, head_valid;
  blz_cmd_t push_cmd, head_cmd;

  blz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  blz_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  blz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for backward_lz77_decompressor: directed and random compressed streams,
// with a behavioral decoder that predicts every output beat. Needs blz_pkg, blz_if, RTL.
module tb;
  import blz_pkg::*;

  localparam int QUIET_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_beat_t;

  logic clk;
  logic rst_n;

  blz_in_if  in_ch();
  blz_cfg_if cfg_ch();
  blz_out_if out_ch();

  backward_lz77_decompressor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // compressed bytes waiting for the driver, decoded bytes waiting for the monitor
  logic [7:0] comp_bytes [$];
  out_beat_t  exp_bytes [$];
  int         bytes_left;
  int         mismatches;

  int  in_gap, out_gap, in_rate, out_rate;
  bit  quiet_tail;
  int  idle_cycles;

  // decoder state
  logic [7:0]        hist [WIN_DEPTH];
  logic [WIN_AW-1:0] m_wptr;
  logic [7:0]        m_flags;
  logic [2:0]        m_tok_idx;
  logic [7:0]        m_pair_hi;
  phase_t            m_phase;
  logic [CFG_W-1:0]  m_count;
  logic [CFG_W-1:0]  m_len;
  bit                m_finished;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void append_byte(ref out_beat_t run [$], input logic [7:0] b);
    hist[m_wptr] = b;
    m_wptr++;
    run.push_back('{data: b, last: 1'b0, done: 1'b0});
  endfunction

  task automatic lz_decode_byte(input logic [7:0] b);
    out_beat_t         run [$];
    int unsigned       cp_dist;
    int unsigned       len;
    logic [WIN_AW-1:0] src;
    bit                token_done;
    token_done = 1'b0;
    if (m_finished) return;
    if (m_count != CNT_MAX) m_count++;
    case (m_phase)
      PH_FLAG: begin
        m_flags = b;
        m_phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        if ((m_flags & FLAG_MSB) == 8'h00) begin
          append_byte(run, b);
          token_done = 1'b1;
        end else begin
          m_pair_hi = b;
          m_phase = PH_PAIR2;
        end
      end
      default: begin
        cp_dist = 32'({m_pair_hi[3:0], b}) + 32'(MIN_MATCH);
        len     = 32'(m_pair_hi[7:4]) + 32'(MIN_MATCH);
        // read byte by byte so an overlapping copy sees its own output
        for (int k = 0; k < len; k++) begin
          src = m_wptr - WIN_AW'(cp_dist);
          append_byte(run, hist[src]);
        end
        token_done = 1'b1;
      end
    endcase
    if (token_done) begin
      m_flags   = m_flags << 1;
      m_tok_idx = m_tok_idx + 3'd1;
      m_phase   = (m_tok_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
      if (m_count >= m_len) m_finished = 1'b1;
    end
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) begin
        run[i].done = m_finished;
        exp_bytes.push_back(run[i]);
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    comp_bytes.push_back(b);
    bytes_left++;
  endtask

  // one flag byte and its eight tokens, random content
  task automatic add_group(output int nbytes);
    logic [7:0] flags;
    logic [7:0] hi;
    case ($urandom_range(0, 7))
      0:       flags = 8'h00;
      1:       flags = 8'hFF;
      default: flags = 8'($urandom);
    endcase
    push_byte(flags);
    nbytes = 1;
    for (int i = 7; i >= 0; i--) begin
      if (flags[i]) begin
        hi = 8'($urandom);
        // favor short distances so most copies read real history
        if ($urandom_range(0, 1) == 0) hi[3:0] = 4'h0;
        push_byte(hi);
        push_byte(8'($urandom));
        nbytes += 2;
      end else begin
        push_byte(8'($urandom));
        nbytes += 1;
      end
    end
  endtask

  task automatic write_len(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.compressed_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    m_len = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (bytes_left != 0 || exp_bytes.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic pick_rates();
    in_rate  = $urandom_range(0, 3);
    out_rate = $urandom_range(0, 3);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        lz_decode_byte(in_ch.in_byte);
        bytes_left--;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (comp_bytes.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (!quiet_tail && in_rate != 0 && $urandom_range(0, 7) < in_rate) begin
          in_gap = $urandom_range(0, 7);
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= comp_bytes.pop_front();
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{data: out_ch.out_byte, last: out_ch.run_last, done: out_ch.stream_done};
        if (exp_bytes.size() == 0) begin
          $display("%0t: unexpected beat byte=%02h last=%0b done=%0b",
                   $time, got.data, got.last, got.done);
          mismatches++;
        end else begin
          want = exp_bytes.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected byte=%02h last=%0b done=%0b,",
                     $time, want.data, want.last, want.done,
                     " actual byte=%02h last=%0b done=%0b",
                     got.data, got.last, got.done);
            mismatches++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_tail && out_rate != 0 && $urandom_range(0, 7) < out_rate) begin
        out_gap = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // end the run if no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int added;
    int n;
    in_ch.valid              = 1'b0;
    in_ch.in_byte            = 8'h00;
    cfg_ch.valid             = 1'b0;
    cfg_ch.compressed_length = '0;
    out_ch.ready             = 1'b0;
    rst_n                    = 1'b0;
    bytes_left  = 0;
    mismatches  = 0;
    in_gap      = 0;
    out_gap     = 0;
    idle_cycles = 0;
    quiet_tail  = 1'b0;
    foreach (hist[i]) hist[i] = 8'h00;
    m_wptr     = '0;
    m_flags    = 8'h00;
    m_tok_idx  = 3'd0;
    m_pair_hi  = 8'h00;
    m_phase    = PH_FLAG;
    m_count    = '0;
    m_len      = '0;
    m_finished = 1'b0;
    pick_rates();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_len(CNT_MAX);
    // all literals, extremes and alternating bits
    push_byte(8'h00);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h55); push_byte(8'hAA);
    push_byte(8'h01); push_byte(8'h80); push_byte(8'h7F); push_byte(8'hFE);
    // four pairs then four literals
    push_byte(8'hF0);
    push_byte(8'h00); push_byte(8'h00);  // shortest copy, nearest distance
    push_byte(8'hF0); push_byte(8'h00);  // longest copy overlapping itself
    push_byte(8'hFF); push_byte(8'hFF);  // reaches behind the first output byte
    push_byte(8'h30); push_byte(8'h01);  // overlap with distance four
    push_byte(8'h12); push_byte(8'h34); push_byte(8'hC3); push_byte(8'h3C);
    wait_drained();

    pick_rates();
    write_len(CFG_W'($urandom_range(4096, CNT_MAX - 1)));
    added = 0;
    while (added < 110) begin
      add_group(n);
      added += n;
      if (n > 12) pick_rates();
    end
    wait_drained();

    // last part: no idling, length set so the stream ends here
    quiet_tail = 1'b1;
    if ($urandom_range(0, 1) == 0)
      write_len('0);
    else
      write_len(m_count + CFG_W'($urandom_range(1, 50)));
    added = 0;
    while (added < 60) begin
      add_group(n);
      added += n;
    end
    wait_drained();

    // stream has ended: further bytes are dropped
    write_len('0);
    for (int i = 0; i < 12; i++) push_byte(8'($urandom));
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
